FILE: src/pps_pkg.sv
`default_nettype none
package pps_pkg;
  localparam int QueueDepth = 16;
  localparam int TimeWidth = 32;
  localparam int MaxResults = 16;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int KW = $clog2(MaxResults + 1);

  localparam logic [1:0] StatusOk = 2'd0;
  localparam logic [1:0] StatusFull = 2'd1;
  localparam logic [1:0] StatusOrder = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_clear;
    logic scan_step;
    logic run;
    logic emit_err;
    logic insert;
    logic set_prev;
  } cmd_t;

  typedef struct packed {
    logic drain;
    logic order_err;
    logic scan_done;
    logic found;
    logic can_run;
    logic has_free;
    logic zero_burst;
    logic limit;
  } sts_t;
endpackage
`default_nettype wire

FILE: src/preemptive_priority_scheduler.sv
// Flow: a check state, then per pick a scan state over all QueueDepth slots and a decide state;
// each slot is shown one pick late. An arrival ends with a post state, and a queue-full result
// also with an output state; an out-of-order arrival goes from the check state straight to
// the output state, where its result shows.
// One item at a time; the receiver cannot stall.
// Asynchronous active-low reset empties the queue and clears clock and previous arrival.
`default_nettype none
module preemptive_priority_scheduler (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        req_type_i,
  input  wire logic [7:0]  proc_id_i,
  input  wire logic [31:0] arrival_time_i,
  input  wire logic [15:0] burst_i,
  input  wire logic [7:0]  priority_req_i,
  output logic             valid_o,
  output logic [7:0]       slot_proc_id_o,
  output logic [31:0]      slot_start_o,
  output logic [15:0]      slot_length_o,
  output logic [7:0]       slot_priority_o,
  output logic [1:0]       status_o,
  output logic             last_o
);
  import pps_pkg::*;
  cmd_t cmd;
  sts_t sts;

  pps_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy), .valid_o(valid_o),
    .last_o(last_o), .cmd_o(cmd), .sts_i(sts)
  );

  pps_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .req_type_i, .proc_id_i,
    .arrival_time_i, .burst_i, .priority_req_i, .slot_proc_id_o, .slot_start_o,
    .slot_length_o, .slot_priority_o, .status_o
  );
endmodule
`default_nettype wire

FILE: src/pps_datapath.sv
`default_nettype none
module pps_datapath (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pps_pkg::cmd_t cmd_i,
  output pps_pkg::sts_t      sts_o,
  input  wire logic          req_type_i,
  input  wire logic [7:0]    proc_id_i,
  input  wire logic [31:0]   arrival_time_i,
  input  wire logic [15:0]   burst_i,
  input  wire logic [7:0]    priority_req_i,
  output logic [7:0]         slot_proc_id_o,
  output logic [31:0]        slot_start_o,
  output logic [15:0]        slot_length_o,
  output logic [7:0]         slot_priority_o,
  output logic [1:0]         status_o
);
  import pps_pkg::*;
  typedef logic [TimeWidth-1:0] tm_t;

  logic [QueueDepth-1:0] valid_q;
  logic [7:0]  id_q [QueueDepth];
  logic [7:0]  pri_q [QueueDepth];
  logic [15:0] rem_q [QueueDepth];
  tm_t         rdy_q [QueueDepth];
  tm_t clock_q, prev_q, at_q;
  logic req_q;
  logic [7:0] pid_q, ppr_q;
  logic [15:0] bt_q;
  logic [IdxW:0] scan_q;
  logic [IdxW-1:0] best_q;
  logic found_q;
  logic [KW-1:0] k_q;

  logic [IdxW-1:0] si;
  logic better;
  tm_t start, gap;
  logic [15:0] run;
  logic [IdxW-1:0] free_idx;
  logic has_free;

  assign si = scan_q[IdxW-1:0];
  assign better = valid_q[si] && (!found_q || pri_q[si] > pri_q[best_q] ||
                  (pri_q[si] == pri_q[best_q] && id_q[si] < id_q[best_q]));

  always_comb begin
    start = (rdy_q[best_q] > clock_q) ? rdy_q[best_q] : clock_q;
    gap = at_q - start;
    run = rem_q[best_q];
    if (!req_q && ({{(TimeWidth>16?TimeWidth-16:0){1'b0}}, run} > gap))
      run = gap[15:0];
    free_idx = '0;
    has_free = 1'b0;
    for (int i = QueueDepth - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
        has_free = 1'b1;
      end
    end
  end

  always_comb begin
    sts_o.drain = req_q;
    sts_o.order_err = at_q < prev_q;
    sts_o.scan_done = scan_q == (IdxW+1)'(QueueDepth);
    sts_o.found = found_q;
    sts_o.can_run = req_q || (start < at_q);
    sts_o.has_free = has_free;
    sts_o.zero_burst = bt_q == 16'd0;
    sts_o.limit = k_q == KW'(MaxResults);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      clock_q <= '0;
      prev_q <= '0;
      scan_q <= '0;
      found_q <= 1'b0;
      k_q <= '0;
    end else begin
      if (cmd_i.load) k_q <= '0;
      if (cmd_i.scan_clear) begin
        scan_q <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        scan_q <= scan_q + 1'b1;
        if (better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.run) begin
        clock_q <= start + TimeWidth'(run);
        if (rem_q[best_q] == run) valid_q[best_q] <= 1'b0;
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.emit_err) k_q <= k_q + 1'b1;
      if (cmd_i.set_prev) prev_q <= at_q;
      if (cmd_i.insert) valid_q[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_type_i;
      pid_q <= proc_id_i;
      at_q <= TimeWidth'(arrival_time_i);
      bt_q <= burst_i;
      ppr_q <= priority_req_i;
    end
    if (cmd_i.scan_step && better) best_q <= si;
    if (cmd_i.insert) begin
      id_q[free_idx] <= pid_q;
      pri_q[free_idx] <= ppr_q;
      rem_q[free_idx] <= bt_q;
      rdy_q[free_idx] <= at_q;
    end
    if (cmd_i.run) begin
      rem_q[best_q] <= rem_q[best_q] - run;
      if (rem_q[best_q] != run) rdy_q[best_q] <= start + TimeWidth'(run);
      slot_proc_id_o <= id_q[best_q];
      slot_start_o <= 32'(start);
      slot_length_o <= run;
      slot_priority_o <= pri_q[best_q];
      status_o <= StatusOk;
    end else if (cmd_i.emit_err) begin
      slot_proc_id_o <= pid_q;
      slot_start_o <= 32'(at_q);
      slot_length_o <= '0;
      slot_priority_o <= ppr_q;
      status_o <= (at_q < prev_q) ? StatusOrder : StatusFull;
    end
  end
endmodule
`default_nettype wire

FILE: src/pps_ctrl.sv
`default_nettype none
module pps_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               valid_o,
  output logic               last_o,
  output pps_pkg::cmd_t      cmd_o,
  input  wire pps_pkg::sts_t sts_i
);
  import pps_pkg::*;
  typedef enum logic [5:0] {
    SIdle  = 6'b000001,
    SCheck = 6'b000010,
    SScan  = 6'b000100,
    SDec   = 6'b001000,
    SPost  = 6'b010000,
    SOut   = 6'b100000
  } state_e;
  state_e state_q, state_d;
  logic pend_q, pend_d;

  // a result is held in the slot registers and shown once the next decision is known
  always_comb begin
    state_d = state_q;
    pend_d = pend_q;
    cmd_o = '0;
    valid_o = 1'b0;
    last_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        pend_d = 1'b0;
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d = SCheck;
        end
      end
      SCheck: begin
        if (!sts_i.drain && sts_i.order_err) begin
          cmd_o.emit_err = 1'b1;
          pend_d = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.scan_clear = 1'b1;
          state_d = SScan;
        end
      end
      SScan: begin
        if (sts_i.scan_done) state_d = SDec;
        else cmd_o.scan_step = 1'b1;
      end
      SDec: begin
        if (sts_i.found && sts_i.can_run && !sts_i.limit) begin
          cmd_o.run = 1'b1;
          cmd_o.scan_clear = 1'b1;
          valid_o = pend_q;
          pend_d = 1'b1;
          state_d = SScan;
        end else if (sts_i.drain) begin
          valid_o = pend_q;
          last_o = pend_q;
          state_d = SIdle;
        end else state_d = SPost;
      end
      SPost: begin
        cmd_o.set_prev = 1'b1;
        valid_o = pend_q;
        if (!sts_i.zero_burst && !sts_i.has_free && !sts_i.limit) begin
          cmd_o.emit_err = 1'b1;
          pend_d = 1'b1;
          state_d = SOut;
        end else begin
          cmd_o.insert = !sts_i.zero_burst && sts_i.has_free;
          last_o = pend_q;
          state_d = SIdle;
        end
      end
      SOut: begin
        valid_o = 1'b1;
        last_o = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      pend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q <= pend_d;
    end
  end

  assign busy_o = state_q != SIdle;
endmodule
`default_nettype wire
